[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the run-length packer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define SRP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("srp assertion failed");

// condition must never be seen at a clock edge outside reset
`define SRP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("srp forbidden condition seen");

`else

`define SRP_ASSERT(lbl, clk, rst_n, prop)
`define SRP_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[hdl/srp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_pkg
// Shared constants and types of the scanline run-length packer.
// ----------------------------------------------------------------------------
package srp_pkg;

	// literal group store
	localparam int LIT_DEPTH = 128;
	localparam int LIT_AW    = $clog2(LIT_DEPTH);

	// repeat codes
	localparam int             MIN_RUN  = 3;
	localparam int             RUN_MAX  = 130;
	localparam logic [7:0]     REP_BASE = 8'h80;
	localparam logic [7:0]     REP_BIAS = REP_BASE - 8'(MIN_RUN);

	// result packing
	localparam int PACK_BYTES = 8;
	localparam int CNT_W      = $clog2(PACK_BYTES + 1);

	typedef logic [7:0] byte_t;

	// controller to packer: one stream byte or an end-of-item mark
	typedef struct packed {
		logic  valid;
		byte_t data;
		logic  done;
	} srp_byte_req_t;

	typedef struct packed {
		logic byte_ready;
		logic done_ready;
	} srp_byte_ack_t;

	// controller to literal store
	typedef struct packed {
		logic              wr_en;
		logic [LIT_AW-1:0] wr_addr;
		byte_t             wr_data;
		logic              rd_en;
		logic [LIT_AW-1:0] rd_addr;
	} srp_mem_req_t;

endpackage

[hdl/srp_pix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_pix_if
// Pixel pair channel: two 4-bit pixels and the end-of-scanline mark.
// ----------------------------------------------------------------------------
interface srp_pix_if;
	logic       valid;
	logic       ready;
	logic [3:0] first_pixel;
	logic [3:0] second_pixel;
	logic       line_end;

	modport source (output valid, output first_pixel, output second_pixel,
		output line_end, input ready);
	modport sink (input valid, input first_pixel, input second_pixel,
		input line_end, output ready);
endinterface

[hdl/srp_code_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_code_if
// Coded byte channel: up to eight stream bytes per transaction.
// ----------------------------------------------------------------------------
interface srp_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte0;
	logic [7:0] out_byte1;
	logic [7:0] out_byte2;
	logic [7:0] out_byte3;
	logic [7:0] out_byte4;
	logic [7:0] out_byte5;
	logic [7:0] out_byte6;
	logic [7:0] out_byte7;
	logic [3:0] byte_count;
	logic       last_of_item;

	modport source (output valid, output out_byte0, output out_byte1,
		output out_byte2, output out_byte3, output out_byte4, output out_byte5,
		output out_byte6, output out_byte7, output byte_count,
		output last_of_item, input ready);
	modport sink (input valid, input out_byte0, input out_byte1,
		input out_byte2, input out_byte3, input out_byte4, input out_byte5,
		input out_byte6, input out_byte7, input byte_count,
		input last_of_item, output ready);
endinterface

[hdl/scanline_rle_packer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_rle_packer
// Run-length codes scanlines of 4-bit pixel pairs, up to eight bytes a result.
// ----------------------------------------------------------------------------
// Each accepted pair becomes one byte (first pixel high). An item that only
// extends a run or starts one leaves pixels.ready high, so runs stream at one
// pair a clock. An item that breaks a run of one or two bytes holds it low
// while those bytes join the literal group, and an item that sends codes
// holds it low while the coded bytes go out, longer while the code side
// stalls: the sequencer moves one byte a cycle and the literal store reads
// one entry a cycle while bytes are taken, and a full group holds 128 bytes.
// Results leave through an output register while the next bytes are gathered;
// last_of_item marks the final result of an item.
module scanline_rle_packer (
	input  logic       clk,
	input  logic       arst_n,
	srp_pix_if.sink    pixels,
	srp_code_if.source codes
);

	srp_pkg::srp_mem_req_t  mem_req;
	srp_pkg::byte_t         mem_rd_data;
	srp_pkg::srp_byte_req_t byte_req;
	srp_pkg::srp_byte_ack_t byte_ack;

	srp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixels      (pixels),
		.mem_req     (mem_req),
		.mem_rd_data (mem_rd_data),
		.byte_req    (byte_req),
		.byte_ack    (byte_ack)
	);

	srp_lit_mem u_lit_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	srp_packer u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_req (byte_req),
		.byte_ack (byte_ack),
		.codes    (codes)
	);

endmodule

[hdl/srp_lit_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_lit_mem
// Literal byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srp_lit_mem (
	input  logic                 clk,
	input  srp_pkg::srp_mem_req_t req,
	output srp_pkg::byte_t       rd_data
);

	srp_pkg::byte_t mem_q [srp_pkg::LIT_DEPTH];
	srp_pkg::byte_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		// read data holds while no read is issued
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/srp_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// srp_ctrl
// Run tracking and code sequencing: emits one coded byte a cycle, if taken.
// ----------------------------------------------------------------------------
module srp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	srp_pix_if.sink               pixels,
	output srp_pkg::srp_mem_req_t mem_req,
	input  srp_pkg::byte_t        mem_rd_data,
	output srp_pkg::srp_byte_req_t byte_req,
	input  srp_pkg::srp_byte_ack_t byte_ack
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CLOSE = 4'd1;
	localparam logic [3:0] S_LHDR  = 4'd2;
	localparam logic [3:0] S_LDAT  = 4'd3;
	localparam logic [3:0] S_RHDR  = 4'd4;
	localparam logic [3:0] S_RVAL  = 4'd5;
	localparam logic [3:0] S_LINE  = 4'd6;
	localparam logic [3:0] S_END   = 4'd7;

	logic [3:0]                  state_q;
	logic [3:0]                  lf_ret_q;
	logic [3:0]                  rpt_ret_q;
	logic [7:0]                  lc_q;
	logic [7:0]                  rc_q;
	srp_pkg::byte_t              rv_q;
	srp_pkg::byte_t              rpt_hdr_q;
	logic [srp_pkg::LIT_AW-1:0]  idx_q;
	logic                        le_phase_q;
	srp_pkg::byte_t              b_q;
	logic                        le_q;

	srp_pkg::byte_t pix_byte;
	logic           in_acc;
	logic           hit;
	logic [7:0]     lc_m1;
	logic           lit_last;
	logic           short_add;
	logic           byte_acc;

	always_comb begin
		pix_byte  = {pixels.first_pixel, pixels.second_pixel};
		in_acc    = pixels.valid && (state_q == S_IDLE);
		hit       = (rc_q != 8'd0) && (pix_byte == rv_q);
		lc_m1     = lc_q - 8'd1;
		lit_last  = ({1'b0, idx_q} == lc_m1);
		short_add = (state_q == S_CLOSE) && (rc_q != 8'd0)
			&& (rc_q < 8'(srp_pkg::MIN_RUN));

		byte_req.valid = 1'b0;
		byte_req.data  = 8'd0;
		byte_req.done  = (state_q == S_END);
		case (state_q)
			S_LHDR: begin
				byte_req.valid = (lc_q != 8'd0);
				byte_req.data  = lc_m1;
			end
			S_LDAT: begin
				byte_req.valid = 1'b1;
				byte_req.data  = mem_rd_data;
			end
			S_RHDR: begin
				byte_req.valid = 1'b1;
				byte_req.data  = rpt_hdr_q;
			end
			S_RVAL: begin
				byte_req.valid = 1'b1;
				byte_req.data  = rv_q;
			end
			default: begin
			end
		endcase
		byte_acc = byte_req.valid && byte_ack.byte_ready;

		mem_req.wr_en   = short_add;
		mem_req.wr_addr = lc_q[srp_pkg::LIT_AW-1:0];
		mem_req.wr_data = rv_q;
		// first read goes out with the group header, the rest one per byte taken
		mem_req.rd_en   = byte_acc && ((state_q == S_LHDR)
			|| ((state_q == S_LDAT) && !lit_last));
		mem_req.rd_addr = (state_q == S_LHDR) ? '0 : idx_q + 1'b1;
	end

	assign pixels.ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			b_q  <= pix_byte;
			le_q <= pixels.line_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lf_ret_q   <= S_END;
			rpt_ret_q  <= S_LINE;
			lc_q       <= 8'd0;
			rc_q       <= 8'd0;
			rv_q       <= 8'd0;
			rpt_hdr_q  <= 8'd0;
			idx_q      <= '0;
			le_phase_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						le_phase_q <= 1'b0;
						if (hit && (rc_q == 8'(srp_pkg::RUN_MAX - 1))) begin
							// run reached its longest code
							rpt_hdr_q <= 8'(srp_pkg::RUN_MAX) + srp_pkg::REP_BIAS;
							rc_q      <= 8'd0;
							lf_ret_q  <= S_RHDR;
							rpt_ret_q <= S_LINE;
							state_q   <= S_LHDR;
						end else if (hit || (rc_q == 8'd0)) begin
							if (hit) begin
								rc_q <= rc_q + 8'd1;
							end else begin
								rv_q <= pix_byte;
								rc_q <= 8'd1;
							end
							if (pixels.line_end) begin
								le_phase_q <= 1'b1;
								state_q    <= S_CLOSE;
							end
						end else begin
							state_q <= S_CLOSE;
						end
					end
				end
				S_CLOSE: begin
					if (rc_q >= 8'(srp_pkg::MIN_RUN)) begin
						rpt_hdr_q <= rc_q + srp_pkg::REP_BIAS;
						rc_q      <= 8'd0;
						lf_ret_q  <= S_RHDR;
						rpt_ret_q <= S_CLOSE;
						state_q   <= S_LHDR;
					end else if (rc_q != 8'd0) begin
						// short candidate joins the literal bytes
						lc_q <= lc_q + 8'd1;
						rc_q <= rc_q - 8'd1;
						if (lc_q == 8'(srp_pkg::LIT_DEPTH - 1)) begin
							lf_ret_q <= S_CLOSE;
							state_q  <= S_LHDR;
						end
					end else if (!le_phase_q) begin
						rv_q <= b_q;
						rc_q <= 8'd1;
						if (le_q) begin
							le_phase_q <= 1'b1;
						end else begin
							state_q <= S_END;
						end
					end else begin
						lf_ret_q <= S_END;
						state_q  <= S_LHDR;
					end
				end
				S_LHDR: begin
					if (lc_q == 8'd0) begin
						state_q <= lf_ret_q;
					end else if (byte_acc) begin
						idx_q   <= '0;
						state_q <= S_LDAT;
					end
				end
				S_LDAT: begin
					if (byte_acc) begin
						if (lit_last) begin
							lc_q    <= 8'd0;
							state_q <= lf_ret_q;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				S_RHDR: begin
					if (byte_acc) begin
						state_q <= S_RVAL;
					end
				end
				S_RVAL: begin
					if (byte_acc) begin
						state_q <= rpt_ret_q;
					end
				end
				S_LINE: begin
					if (le_q) begin
						le_phase_q <= 1'b1;
						state_q    <= S_CLOSE;
					end else begin
						state_q <= S_END;
					end
				end
				S_END: begin
					if (byte_ack.done_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SRP_ASSERT_NEVER(a_lit_count_range, clk, arst_n, lc_q > 8'(srp_pkg::LIT_DEPTH))
	`SRP_ASSERT_NEVER(a_run_below_max, clk, arst_n, rc_q >= 8'(srp_pkg::RUN_MAX))
	`SRP_ASSERT(a_ldat_has_bytes, clk, arst_n, (state_q == S_LDAT) |-> (lc_q != 8'd0))
	`SRP_ASSERT(a_write_leaves_room, clk, arst_n, short_add |=> (lc_q != 8'd0))

endmodule

[hdl/srp_packer.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// srp_packer
// Packs up to eight stream bytes a transaction and holds the output register.
// ----------------------------------------------------------------------------
module srp_packer (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srp_pkg::srp_byte_req_t byte_req,
	output srp_pkg::srp_byte_ack_t byte_ack,
	srp_code_if.source             codes
);

	localparam logic [srp_pkg::CNT_W-1:0] FULL = srp_pkg::CNT_W'(srp_pkg::PACK_BYTES);

	srp_pkg::byte_t               acc_q  [srp_pkg::PACK_BYTES];
	srp_pkg::byte_t               obyte_q[srp_pkg::PACK_BYTES];
	logic [srp_pkg::CNT_W-1:0]    cnt_q;
	logic [srp_pkg::CNT_W-1:0]    ocnt_q;
	logic                         olast_q;
	logic                         ov_q;

	logic slot_free;
	logic full;
	logic byte_acc;
	logic done_acc;
	logic push;

	always_comb begin
		slot_free           = !ov_q || codes.ready;
		full                = (cnt_q == FULL);
		// a full word waits for the next byte to learn it is not the last
		byte_ack.byte_ready = !full || slot_free;
		byte_ack.done_ready = (cnt_q == '0) || slot_free;
		byte_acc            = byte_req.valid && byte_ack.byte_ready;
		done_acc            = byte_req.done && byte_ack.done_ready;
		push                = (byte_acc && full) || (done_acc && (cnt_q != '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (byte_acc) begin
				cnt_q <= full ? srp_pkg::CNT_W'(1) : cnt_q + 1'b1;
			end else if (done_acc) begin
				cnt_q <= '0;
			end
			if (push) begin
				ov_q <= 1'b1;
			end else if (codes.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc) begin
			if (full) begin
				acc_q[0] <= byte_req.data;
			end else begin
				acc_q[cnt_q[srp_pkg::CNT_W-2:0]] <= byte_req.data;
			end
		end
		if (push) begin
			for (int j = 0; j < srp_pkg::PACK_BYTES; j++) begin
				obyte_q[j] <= (srp_pkg::CNT_W'(j) < cnt_q) ? acc_q[j] : 8'd0;
			end
			ocnt_q  <= cnt_q;
			olast_q <= done_acc;
		end
	end

	assign codes.valid        = ov_q;
	assign codes.out_byte0    = obyte_q[0];
	assign codes.out_byte1    = obyte_q[1];
	assign codes.out_byte2    = obyte_q[2];
	assign codes.out_byte3    = obyte_q[3];
	assign codes.out_byte4    = obyte_q[4];
	assign codes.out_byte5    = obyte_q[5];
	assign codes.out_byte6    = obyte_q[6];
	assign codes.out_byte7    = obyte_q[7];
	assign codes.byte_count   = ocnt_q;
	assign codes.last_of_item = olast_q;

	`SRP_ASSERT_NEVER(a_no_overwrite, clk, arst_n, push && ov_q && !codes.ready)
	`SRP_ASSERT(a_count_range, clk, arst_n, ov_q |-> ((ocnt_q != '0) && (ocnt_q <= FULL)))
	`SRP_ASSERT_NEVER(a_byte_or_done, clk, arst_n, byte_req.valid && byte_req.done)
	`SRP_ASSERT(a_done_empties, clk, arst_n, done_acc |=> (cnt_q == '0))

endmodule
